// ===== rtl/core/smsf_pkg.sv =====
`default_nettype none
package smsf_pkg;
  localparam int SET_DEPTH = 64;
  localparam int IDX_W = $clog2(SET_DEPTH);
  localparam int CNT_W = $clog2(SET_DEPTH + 1);
  localparam int VAL_W = 32;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_FILTER = 2'd2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/smsf_ram.sv =====
`default_nettype none
module smsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/smsf_scan.sv =====
`default_nettype none
module smsf_scan
  import smsf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scan_req_t        req,
  input  wire logic [VAL_W-1:0] key,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [VAL_W-1:0] wr_data,
  output      scan_rsp_t        rsp
);
  logic             active_r, active_nxt;
  logic             cmp_r, cmp_nxt;
  logic             hit_r, hit_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic [VAL_W-1:0] rdata;
  logic             done_w;

  smsf_ram #(.WIDTH(VAL_W), .DEPTH(SET_DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  // cmp_r marks that rdata holds a valid entry read last cycle
  always_comb begin
    active_nxt = active_r;
    cmp_nxt    = 1'b0;
    hit_nxt    = hit_r;
    rd_cnt_nxt = rd_cnt_r;
    lim_nxt    = lim_r;
    done_w     = 1'b0;
    if (req.start) begin
      active_nxt = 1'b1;
      hit_nxt    = 1'b0;
      rd_cnt_nxt = '0;
      lim_nxt    = req.count;
    end else if (active_r) begin
      if (cmp_r && rdata == key) begin
        hit_nxt = 1'b1;
      end
      if (rd_cnt_r < lim_r) begin
        cmp_nxt    = 1'b1;
        rd_cnt_nxt = rd_cnt_r + 1'b1;
      end else if (!cmp_r) begin
        active_nxt = 1'b0;
        done_w     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cmp_r    <= 1'b0;
      hit_r    <= 1'b0;
      rd_cnt_r <= '0;
      lim_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cmp_r    <= cmp_nxt;
      hit_r    <= hit_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      lim_r    <= lim_nxt;
    end
  end

  assign rsp.done = done_w;
  assign rsp.hit  = hit_r;
endmodule
`default_nettype wire

// ===== rtl/core/set_membership_stream_filter_unit.sv =====
// Channel | Ports                                  | Handshake
// in      | in_func, in_value, in_last             | start & !busy
// out     | out_value_out, out_kept, out_last_out,  | out_strobe, one cycle
//         | out_status                             |
// A clear item or an unused code skips the scan. Insert and filter items scan
// the set memory one entry per cycle through its single read port, covering
// only the stored values (at most SET_DEPTH). Reset is synchronous and
// empties the set; no memory sweep is needed since a fill count bounds every
// scan. The receiver cannot stall: results are shown for one cycle with
// out_strobe.
`default_nettype none
module set_membership_stream_filter_unit
  import smsf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output      logic                    busy,
  input  wire logic [1:0]              in_func,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire logic                    in_last,
  output      logic                    out_strobe,
  output      logic signed [VAL_W-1:0] out_value_out,
  output      logic                    out_kept,
  output      logic                    out_last_out,
  output      logic                    out_status
);
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [1:0]       func_r;
  logic [VAL_W-1:0] val_r;
  logic             last_r;
  logic             strobe_r, strobe_nxt;
  logic             kept_r, kept_nxt;
  logic             status_r, status_nxt;
  logic             wr_en;
  scan_req_t        req;
  scan_rsp_t        rsp;
  logic             accept;

  assign accept    = start && !busy;
  assign req.start = accept && (in_func == FUNC_INSERT || in_func == FUNC_FILTER);
  assign req.count = fill_r;

  smsf_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .key     (val_r),
    .wr_en   (wr_en),
    .wr_addr (fill_r[IDX_W-1:0]),
    .wr_data (val_r),
    .rsp     (rsp)
  );

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    strobe_nxt = 1'b0;
    kept_nxt   = kept_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = req.start ? ST_SCAN : ST_DONE;
          if (in_func == FUNC_CLEAR) begin
            fill_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (rsp.done) begin
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
          kept_nxt   = 1'b0;
          status_nxt = 1'b0;
          if (func_r == FUNC_FILTER) begin
            kept_nxt = !rsp.hit;
          end else if (!rsp.hit) begin
            // append at fill index, or drop when full
            if (fill_r < CNT_W'(SET_DEPTH)) begin
              wr_en    = 1'b1;
              fill_nxt = fill_r + 1'b1;
            end else begin
              status_nxt = 1'b1;
            end
          end
        end
      end
      ST_DONE: begin
        state_nxt  = ST_IDLE;
        strobe_nxt = 1'b1;
        kept_nxt   = 1'b0;
        status_nxt = 1'b0;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      val_r  <= in_value;
      last_r <= in_last;
    end
    kept_r   <= kept_nxt;
    status_r <= status_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_strobe    = strobe_r;
  assign out_value_out = val_r;
  assign out_kept      = kept_r;
  assign out_last_out  = last_r;
  assign out_status    = status_r;
endmodule
`default_nettype wire

// ===== rtl/core/smsf_checker.sv =====
`default_nettype none
module smsf_checker
  import smsf_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             out_strobe,
  input wire logic             out_kept,
  input wire logic             out_status
);
  // accepted beat makes the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after accept");
  // no result without a preceding busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("stray result");
  a_strobe_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("busy with result");
  a_kept_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_kept && out_status)) else $error("kept and dropped");
endmodule

bind set_membership_stream_filter_unit smsf_checker u_smsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_kept   (out_kept),
  .out_status (out_status)
);
`default_nettype wire
